// ----- src/cgc_pkg.sv -----
package cgc_pkg;

   localparam int MASK_BITS = 256;
   localparam int DEFAULT_MAX_GROUPS = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [MASK_BITS-1:0] mask_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       char_valid;
      logic       end_of_string;
   } req_word_type;

   typedef struct packed {
      logic [3:0] group_index;
      logic       new_group;
      logic       table_overflow;
   } rsp_word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- src/cgc_ram.sv -----
module cgc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- src/cgc_front.sv -----
module cgc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cgc_pkg::req_word_type     req_word,
   input  cgc_pkg::queue_status_type q_status,
   output logic                      push,
   output cgc_pkg::mask_type         push_mask
);
   import cgc_pkg::*;

   mask_type mask_ff;
   mask_type mask_in;
   mask_type merged;
   logic     accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      merged = mask_ff;
      if (req_word.char_valid) begin
         merged[req_word.char_code] = 1'b1;
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (accept) begin
         mask_in = req_word.end_of_string ? '0 : merged;
      end
   end

   assign push      = accept && req_word.end_of_string;
   assign push_mask = merged;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

endmodule

// ----- src/cgc_queue.sv -----
module cgc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cgc_pkg::mask_type         push_mask,
   input  logic                      pop,
   output cgc_pkg::mask_type         head_mask,
   output cgc_pkg::queue_status_type q_status
);
   import cgc_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CntW-1:0] FullCount = CntW'(QUEUE_DEPTH);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

   mask_type        slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == FullCount);
   assign q_status.empty = (count_ff == '0);
   assign head_mask      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/cgc_back.sv -----
module cgc_back #(
   parameter int MAX_GROUPS = cgc_pkg::DEFAULT_MAX_GROUPS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cgc_pkg::queue_status_type q_status,
   input  cgc_pkg::mask_type         head_mask,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cgc_pkg::rsp_word_type     rsp_word
);
   import cgc_pkg::*;

   localparam int CntW = $clog2(MAX_GROUPS + 1);
   localparam int AddrW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam logic [CntW-1:0] MaxCount = CntW'(MAX_GROUPS);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_CHECK = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] count_ff, count_in;
   rsp_word_type    result_ff, result_in;
   logic            rd_en;
   logic            wr_en;
   mask_type        rd_data;

   cgc_ram #(
      .WIDTH (MASK_BITS),
      .DEPTH (MAX_GROUPS)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[AddrW-1:0]),
      .wr_data    (head_mask),
      .rd_en      (rd_en),
      .rd_addr    (idx_ff[AddrW-1:0]),
      .rd_data_ff (rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      result_in = result_ff;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      pop       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               idx_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (idx_ff < count_ff) begin
               rd_en    = 1'b1;
               state_in = S_CHECK;
            end else if (count_ff != MaxCount) begin
               // unseen set, store it under the next index
               wr_en     = 1'b1;
               count_in  = count_ff + 1'b1;
               result_in = '{group_index: 4'(count_ff), new_group: 1'b1,
                             table_overflow: 1'b0};
               state_in  = S_RESP;
            end else begin
               result_in = '{group_index: 4'd0, new_group: 1'b0,
                             table_overflow: 1'b1};
               state_in  = S_RESP;
            end
         end
         S_CHECK: begin
            if (rd_data == head_mask) begin
               result_in = '{group_index: 4'(idx_ff), new_group: 1'b0,
                             table_overflow: 1'b0};
               state_in  = S_RESP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               pop      = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_word  = result_ff;

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- src/charset_group_classifier_top.sv -----
// channel   ports                            carries
// request   req_valid, req_stall, req_word   one character item per word
// response  rsp_valid, rsp_stall, rsp_word   group result, one per string end
//
// the front takes one word per cycle and stalls only when both queue slots hold
// finished masks. the back picks up the queue head, then for each stored group
// it reads the table ram entry and compares it with the head; on a match it shows
// the result, and if none matches it stores the set or flags overflow, then shows
// the result and holds it while the response side stalls.
// reset clears the running mask, the queue and the group count; the table
// itself is not cleared, only entries below the count are read.
module charset_group_classifier_top #(
   parameter int MAX_GROUPS = cgc_pkg::DEFAULT_MAX_GROUPS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cgc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cgc_pkg::rsp_word_type rsp_word
);
   import cgc_pkg::*;

   queue_status_type q_status;
   logic             push;
   logic             pop;
   mask_type         push_mask;
   mask_type         head_mask;

   cgc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_status  (q_status),
      .push      (push),
      .push_mask (push_mask)
   );

   cgc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_mask (push_mask),
      .pop       (pop),
      .head_mask (head_mask),
      .q_status  (q_status)
   );

   cgc_back #(
      .MAX_GROUPS (MAX_GROUPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_mask (head_mask),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import cgc_pkg::*;

   localparam int TABLE_GROUPS = DEFAULT_MAX_GROUPS;
   localparam int RANDOM_WORDS = 1700;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 2 * TABLE_GROUPS + 32;

   typedef struct {
      req_word_type word;
      bit           drain;
   } pending_word_type;

   typedef enum {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   charset_group_classifier_top #(
      .MAX_GROUPS(TABLE_GROUPS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   always #1 clock = ~clock;

   // predictor state
   mask_type     seen_set = '0;
   mask_type     group_set [TABLE_GROUPS];
   int unsigned  groups_stored = 0;

   pending_word_type pending_words [$];
   rsp_word_type     expected_groups [$];
   int unsigned      words_total = 0;
   int unsigned      words_accepted = 0;
   int unsigned      results_seen = 0;
   int unsigned      mismatches = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // updates the running set; at a string end works out the group result
   task automatic classify_word(input req_word_type w);
      rsp_word_type r;
      int           hit;
      int           g;
      if (w.char_valid) begin
         seen_set[w.char_code] = 1'b1;
      end
      if (w.end_of_string) begin
         hit = -1;
         for (g = 0; g < int'(groups_stored); g++) begin
            if (hit < 0 && group_set[g] == seen_set) begin
               hit = g;
            end
         end
         r = '0;
         if (hit >= 0) begin
            r.group_index = 4'(hit);
         end else if (groups_stored < TABLE_GROUPS) begin
            group_set[groups_stored] = seen_set;
            r.group_index = 4'(groups_stored);
            r.new_group = 1'b1;
            groups_stored++;
         end else begin
            r.table_overflow = 1'b1;
         end
         seen_set = '0;
         expected_groups.insert(expected_groups.size(), r);
      end
   endtask

   task automatic add_word(input logic [7:0] code, input logic valid, input logic eos,
                           input bit drain);
      pending_word_type p;
      p.word.char_code = code;
      p.word.char_valid = valid;
      p.word.end_of_string = eos;
      p.drain = drain;
      pending_words.insert(pending_words.size(), p);
      words_total++;
   endtask

   // sender: bursts of random length with random gaps
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            classify_word(req_word);
            words_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() == 0 ||
                         (pending_words[0].drain && expected_groups.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req_word <= pending_words[0].word;
               req_valid <= 1'b1;
               void'(pending_words.pop_front());
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // receiver: stall pattern changes from stretch to stretch, one long hold-off
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    mode_left = 0;
   int unsigned    hold_left = 0;
   bit             long_hold_done = 1'b0;

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_groups.size() == 0) begin
               report_mismatch($sformatf("result word %0h with no string waiting", rsp_word));
            end else begin
               want = expected_groups.pop_front();
               if (rsp_word.group_index !== want.group_index)
                  report_mismatch($sformatf("result %0d: group_index %0d, want %0d",
                                            results_seen, rsp_word.group_index,
                                            want.group_index));
               if (rsp_word.new_group !== want.new_group)
                  report_mismatch($sformatf("result %0d: new_group %0b, want %0b",
                                            results_seen, rsp_word.new_group, want.new_group));
               if (rsp_word.table_overflow !== want.table_overflow)
                  report_mismatch($sformatf("result %0d: table_overflow %0b, want %0b",
                                            results_seen, rsp_word.table_overflow,
                                            want.table_overflow));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && results_seen >= 120) begin
            // sender keeps going, so the queue fills and the front stalls
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE: begin
                  rsp_stall <= 1'b0;
               end
               STALL_LIGHT: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               STALL_HEAVY: begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_stall <= (mode_left % 3 != 0);
               end
            endcase
         end
      end
   end

   logic [7:0] char_pool [5];

   initial begin
      int unsigned counted;
      int          len;
      int          i;
      int          roll;
      bit          drain_next;
      bit          mid_drain_done;
      logic        last;
      logic [7:0]  c;

      // empty string, then single extreme characters
      add_word(8'h00, 1'b0, 1'b1, 1'b0);
      add_word(8'h00, 1'b1, 1'b1, 1'b0);
      add_word(8'hff, 1'b1, 1'b0, 1'b0);
      add_word(8'hab, 1'b0, 1'b1, 1'b0);
      // codes on invalid words are ignored, so this is the empty set again
      add_word(8'hff, 1'b0, 1'b0, 1'b0);
      add_word(8'h5a, 1'b0, 1'b1, 1'b0);
      // repeated character matches the single-character set
      add_word(8'h00, 1'b1, 1'b0, 1'b0);
      add_word(8'h00, 1'b1, 1'b1, 1'b0);
      // order of characters does not matter
      add_word(8'hff, 1'b1, 1'b0, 1'b0);
      add_word(8'h00, 1'b1, 1'b1, 1'b0);
      add_word(8'h00, 1'b1, 1'b0, 1'b0);
      add_word(8'hff, 1'b1, 1'b1, 1'b0);
      // characters either side of each 64-bit boundary of the mask
      add_word(8'd63, 1'b1, 1'b0, 1'b0);
      add_word(8'd64, 1'b1, 1'b0, 1'b0);
      add_word(8'd127, 1'b1, 1'b0, 1'b0);
      add_word(8'd128, 1'b1, 1'b0, 1'b0);
      add_word(8'd191, 1'b1, 1'b0, 1'b0);
      add_word(8'd192, 1'b1, 1'b1, 1'b0);

      // small alphabet so that sets repeat and the table fills gradually
      for (i = 0; i < 5; i++) begin
         char_pool[i] = 8'($urandom_range(0, 255));
      end
      counted = 0;
      drain_next = 1'b1;
      mid_drain_done = 1'b0;
      while (counted < RANDOM_WORDS) begin
         if (!mid_drain_done && counted >= RANDOM_WORDS / 2) begin
            mid_drain_done = 1'b1;
            drain_next = 1'b1;
         end
         roll = $urandom_range(0, 99);
         len = (roll % 20 == 0) ? 0 : $urandom_range(1, 6);
         last = 1'b0;
         for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, drain_next);
               drain_next = 1'b0;
            end
            c = (roll < 65) ? char_pool[$urandom_range(0, 4)] : 8'($urandom_range(0, 255));
            last = (i == len - 1) && ($urandom_range(0, 2) != 0);
            add_word(c, 1'b1, last, drain_next);
            drain_next = 1'b0;
            counted++;
         end
         if (!last) begin
            add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain_next);
            drain_next = 1'b0;
            counted++;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (words_accepted != words_total) @(posedge clock);
      while (expected_groups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d of %0d words sent, %0d results waiting",
               words_accepted, words_total, expected_groups.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- charset_group_classifier_top.f -----
src/cgc_pkg.sv
src/cgc_ram.sv
src/cgc_front.sv
src/cgc_queue.sv
src/cgc_back.sv
src/charset_group_classifier_top.sv
tb/tb_top.sv
